/* src/sss_pkg.sv */
package sss_pkg;

  // Text size limit and offset width
  localparam int unsigned MaxTextBytes = 65536;
  localparam int unsigned OffsetW      = 17;

  // Character codes
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChSlash = 8'h2F;

  // Open-section code when no section is open
  localparam logic [2:0] SecNone = 3'd7;

  // Header name lengths: init, slider, block, sample
  localparam logic [3:0][2:0] HdrLen = {3'd6, 3'd5, 3'd6, 3'd4};

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_AT,
    PH_NAME,
    PH_TRAIL,
    PH_SLASH,
    PH_COMMENT,
    PH_REJECT
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_SAMPLE,
    ST_DUPLICATE,
    ST_TOO_LONG
  } status_e;

  typedef struct packed {
    phase_e                   phase;
    logic [2:0]               nlen;
    logic [3:0]               nmatch;
    logic [2:0]               cur;
    logic [3:0]               marks;
    logic [3:0][OffsetW-1:0]  starts;
    logic [3:0][OffsetW-1:0]  slens;
    logic [OffsetW-1:0]       offset;
    logic [OffsetW-1:0]       lstart;
    status_e                  status;
  } state_t;

  // Final section table handed from the parser to the record emitter
  typedef struct packed {
    logic [3:0]               marks;
    logic [3:0][OffsetW-1:0]  starts;
    logic [3:0][OffsetW-1:0]  slens;
    status_e                  status;
  } rec_set_t;

  typedef struct packed {
    logic     load;
    rec_set_t set;
  } rec_load_t;

  function automatic state_t reset_state();
    state_t r;
    r        = '0;
    r.phase  = PH_LEAD;
    r.nmatch = 4'hF;
    r.cur    = SecNone;
    r.status = ST_OK;
    return r;
  endfunction

  // Character at a position of a known header name
  function automatic logic [7:0] hdr_char(input logic [1:0] sec, input logic [2:0] pos);
    logic [47:0] nm;
    logic [47:0] sh;
    case (sec)
      2'd0:    nm = {"init", 16'h0000};
      2'd1:    nm = "slider";
      2'd2:    nm = {"block", 8'h00};
      default: nm = "sample";
    endcase
    sh = nm << {pos, 3'b000};
    return sh[47:40];
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
  endfunction

endpackage

/* src/sss_parser.sv */
module sss_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                has_byte_i,
  input  logic [7:0]          text_byte_i,
  input  logic                end_of_text_i,
  input  logic                busy_i,
  output sss_pkg::rec_load_t  rec_o
);

  logic                 in_valid_q;
  logic                 has_q;
  logic [7:0]           byte_q;
  logic                 eot_q;
  logic                 advance;
  sss_pkg::state_t      st_q;
  sss_pkg::state_t      st_d;
  sss_pkg::rec_set_t    set_d;

  // Close the line that just ended and open a section for a known header
  function automatic sss_pkg::state_t end_line(input sss_pkg::state_t s,
                                               input logic [sss_pkg::OffsetW-1:0] nxt);
    sss_pkg::state_t r;
    logic            hdr;
    logic            known;
    logic [1:0]      k;
    r     = s;
    hdr   = s.phase == sss_pkg::PH_NAME || s.phase == sss_pkg::PH_TRAIL ||
            s.phase == sss_pkg::PH_COMMENT;
    known = 1'b0;
    k     = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (!known && s.nmatch[i] && s.nlen == sss_pkg::HdrLen[i]) begin
        known = 1'b1;
        k     = 2'(i);
      end
    end
    if (hdr) begin
      if (!s.cur[2]) begin
        r.slens[s.cur[1:0]] = s.lstart - s.starts[s.cur[1:0]];
      end
      r.cur = sss_pkg::SecNone;
      if (known) begin
        if (s.marks[k]) begin
          r.status = sss_pkg::ST_DUPLICATE;
        end else begin
          r.marks[k]  = 1'b1;
          r.starts[k] = nxt;
          r.cur       = {1'b0, k};
        end
      end
    end
    return r;
  endfunction

  // Narrow the candidate names by one more name character
  function automatic sss_pkg::state_t name_char(input sss_pkg::state_t s,
                                                input logic [7:0] c);
    sss_pkg::state_t r;
    r = s;
    if (s.nlen != 3'd7) begin
      for (int i = 0; i < 4; i++) begin
        if (s.nlen >= sss_pkg::HdrLen[i] || sss_pkg::hdr_char(2'(i), s.nlen) != c) begin
          r.nmatch[i] = 1'b0;
        end
      end
      r.nlen = s.nlen + 3'd1;
    end
    return r;
  endfunction

  // Hold an end-of-text request in the input register while the emitter still owns the last table
  assign in_stall_o = in_valid_q && eot_q && busy_i;
  assign advance    = in_valid_q && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      has_q  <= has_byte_i;
      byte_q <= text_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  // Update the line state for one byte, then close out the text on end of text
  always_comb begin
    sss_pkg::state_t s;
    sss_pkg::state_t f;
    logic [sss_pkg::OffsetW-1:0] nxt;
    s   = st_q;
    nxt = sss_pkg::OffsetW'(st_q.offset + 1'b1);
    if (has_q && st_q.status == sss_pkg::ST_OK) begin
      if (st_q.offset >= sss_pkg::OffsetW'(sss_pkg::MaxTextBytes)) begin
        s.status = sss_pkg::ST_TOO_LONG;
      end else begin
        s.offset = nxt;
        if (byte_q == sss_pkg::ChNl) begin
          s = end_line(s, nxt);
          if (s.status == sss_pkg::ST_OK) begin
            s.phase  = sss_pkg::PH_LEAD;
            s.nlen   = 3'd0;
            s.nmatch = 4'hF;
            s.lstart = nxt;
          end
        end else begin
          case (st_q.phase)
            sss_pkg::PH_LEAD: begin
              if (byte_q == sss_pkg::ChAt) begin
                s.phase = sss_pkg::PH_AT;
              end else if (byte_q != sss_pkg::ChSpace && byte_q != sss_pkg::ChTab) begin
                s.phase = sss_pkg::PH_REJECT;
              end
            end
            sss_pkg::PH_AT: begin
              if (sss_pkg::is_name_char(byte_q)) begin
                s       = name_char(s, byte_q);
                s.phase = sss_pkg::PH_NAME;
              end else begin
                s.phase = sss_pkg::PH_REJECT;
              end
            end
            sss_pkg::PH_NAME: begin
              if (sss_pkg::is_name_char(byte_q)) begin
                s = name_char(s, byte_q);
              end else if (byte_q == sss_pkg::ChSpace || byte_q == sss_pkg::ChTab ||
                           byte_q == sss_pkg::ChCr) begin
                s.phase = sss_pkg::PH_TRAIL;
              end else if (byte_q == sss_pkg::ChSlash) begin
                s.phase = sss_pkg::PH_SLASH;
              end else begin
                s.phase = sss_pkg::PH_REJECT;
              end
            end
            sss_pkg::PH_TRAIL: begin
              if (byte_q == sss_pkg::ChSlash) begin
                s.phase = sss_pkg::PH_SLASH;
              end else if (byte_q != sss_pkg::ChSpace && byte_q != sss_pkg::ChTab &&
                           byte_q != sss_pkg::ChCr) begin
                s.phase = sss_pkg::PH_REJECT;
              end
            end
            sss_pkg::PH_SLASH: begin
              s.phase = (byte_q == sss_pkg::ChSlash) ? sss_pkg::PH_COMMENT
                                                     : sss_pkg::PH_REJECT;
            end
            sss_pkg::PH_COMMENT: begin
              s.phase = sss_pkg::PH_COMMENT;
            end
            default: begin
              s.phase = sss_pkg::PH_REJECT;
            end
          endcase
        end
      end
    end

    // Close the trailing line and the open section
    f = s;
    if (s.status == sss_pkg::ST_OK) begin
      f = end_line(s, s.offset);
      if (f.status == sss_pkg::ST_OK && !f.cur[2]) begin
        f.slens[f.cur[1:0]] = f.offset - f.starts[f.cur[1:0]];
      end
    end
    set_d.marks  = f.marks;
    set_d.starts = f.starts;
    set_d.slens  = f.slens;
    if (f.status != sss_pkg::ST_OK) begin
      set_d.status = f.status;
    end else begin
      set_d.status = f.marks[3] ? sss_pkg::ST_OK : sss_pkg::ST_NO_SAMPLE;
    end

    st_d = eot_q ? sss_pkg::reset_state() : s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sss_pkg::reset_state();
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  assign rec_o.load = advance && eot_q;
  assign rec_o.set  = set_d;

endmodule

/* src/sss_emitter.sv */
module sss_emitter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sss_pkg::rec_load_t           rec_i,
  output logic                         busy_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   section_id_o,
  output logic                         present_o,
  output logic [sss_pkg::OffsetW-1:0]  start_offset_o,
  output logic [sss_pkg::OffsetW-1:0]  section_length_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);

  logic               pend_q;
  logic [1:0]         idx_q;
  sss_pkg::rec_set_t  set_q;
  logic               take;

  assign take = pend_q && !out_stall_i;

  // Advance through the four records, drop the table after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (rec_i.load) begin
      pend_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (take) begin
      if (idx_q == 2'd3) begin
        pend_q <= 1'b0;
      end
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_i.load) begin
      set_q <= rec_i.set;
    end
  end

  assign busy_o           = pend_q;
  assign out_valid_o      = pend_q;
  assign section_id_o     = idx_q;
  assign present_o        = set_q.marks[idx_q];
  assign start_offset_o   = set_q.starts[idx_q];
  assign section_length_o = set_q.slens[idx_q];
  assign status_o         = set_q.status;
  assign last_o           = idx_q == 2'd3;

endmodule

/* src/script_section_splitter.sv */
// Script section splitter.
// Input channel: one request per text byte (has_byte_i, text_byte_i) with
// end_of_text_i on the final request; a request with has_byte_i low carries
// only the end mark. A request is taken when in_valid_i is high and
// in_stall_o is low. Bytes are taken one per cycle while in_stall_o is low.
// Output channel: after each end of text, four section records leave in
// order init, slider, block, sample, the last one with last_o high; one is
// taken per cycle when out_valid_o is high and out_stall_i is low.
// The end-of-text request, once taken, waits in the input register, then
// loads the record table register, from which the first record is offered.
// Parsing of the next text goes on while records drain; only a further
// end-of-text request waits in the input register until all four records
// are gone, so a stalled receiver holds back the next text from that point.
// Reset clears the parse state and drops any records not yet taken; the
// record table holds one text at a time.
module script_section_splitter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         has_byte_i,
  input  logic [7:0]                   text_byte_i,
  input  logic                         end_of_text_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   section_id_o,
  output logic                         present_o,
  output logic [sss_pkg::OffsetW-1:0]  start_offset_o,
  output logic [sss_pkg::OffsetW-1:0]  section_length_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);

  sss_pkg::rec_load_t rec;
  logic               busy;

  sss_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .has_byte_i    (has_byte_i),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .busy_i        (busy),
    .rec_o         (rec)
  );

  sss_emitter u_emitter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_i            (rec),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .section_id_o     (section_id_o),
    .present_o        (present_o),
    .start_offset_o   (start_offset_o),
    .section_length_o (section_length_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule

/* src/sss_checker.sv */
module sss_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [1:0]                   section_id_o,
  input logic                         present_o,
  input logic [sss_pkg::OffsetW-1:0]  start_offset_o,
  input logic [sss_pkg::OffsetW-1:0]  section_length_o,
  input logic [1:0]                   status_o,
  input logic                         last_o
);

  // Stalled record stays offered
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("record dropped while stalled");

  // Records of one text follow each other in section order
  a_next_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && section_id_o == $past(section_id_o) + 2'd1)
    else $error("section record missing or out of order");

  // Last flag marks the sample record only
  a_last_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (section_id_o == 2'd3)))
    else $error("last flag on wrong record");

  // All records of one text carry the same status
  a_status_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> status_o == $past(status_o))
    else $error("status changed within one text");

  // Absent section reports no extent
  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !present_o |-> start_offset_o == '0 && section_length_o == '0)
    else $error("absent section with nonzero extent");

endmodule

bind script_section_splitter sss_checker u_sss_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .section_id_o     (section_id_o),
  .present_o        (present_o),
  .start_offset_o   (start_offset_o),
  .section_length_o (section_length_o),
  .status_o         (status_o),
  .last_o           (last_o)
);
